FILE: design/gbcq_pkg.sv
// Shared codes and constants for the grid box collision query unit.
// No dependencies.
package gbcq_pkg;
    localparam logic [1:0] OP_WALL    = 2'd0;
    localparam logic [1:0] OP_FLOOR   = 2'd1;
    localparam logic [1:0] OP_CEILING = 2'd2;
    localparam logic [1:0] OP_QUERY   = 2'd3;

    localparam logic [2:0] REG_GRID_WIDTH      = 3'd0;
    localparam logic [2:0] REG_GRID_HEIGHT     = 3'd1;
    localparam logic [2:0] REG_CELL_SIZE       = 3'd2;
    localparam logic [2:0] REG_DEFAULT_FLOOR   = 3'd3;
    localparam logic [2:0] REG_DEFAULT_CEILING = 3'd4;

    localparam logic signed [15:0] CEILING_RESET = 16'sd768;
    localparam int DIV_STEPS = 24;

    typedef logic signed [25:0] cell_coord_t;
endpackage

FILE: design/gbcq_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module gbcq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: design/grid_box_collision_query_unit.sv
// Grid box collision query unit. A write word is taken in the idle state. A query runs four
// divisions in the shared restoring divider, a clamp state, a walk over each covered
// in-bounds cell, a drain state (skipped with no cell covered) and an output state; the
// next word waits for the query to finish, and a held result stalls it. Reset loads the
// register defaults and clears all MAX_COLUMNS * MAX_ROWS cell RAM entries before the first word.
// Depends on gbcq_pkg and gbcq_ram.
module grid_box_collision_query_unit
    import gbcq_pkg::*;
#(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic signed [7:0]  cell_x,
    input  logic signed [7:0]  cell_y,
    input  logic               wall_flag,
    input  logic signed [15:0] height_value,
    input  logic signed [23:0] center_x,
    input  logic signed [23:0] center_z,
    input  logic [10:0]        radius,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               blocked,
    output logic signed [15:0] max_floor,
    output logic signed [15:0] min_ceiling,
    output logic               any_open,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int YW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_CLAMP = 3'd4;
    localparam logic [2:0] ST_WALK  = 3'd5;
    localparam logic [2:0] ST_DRAIN = 3'd6;
    localparam logic [2:0] ST_FIN   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg;

    logic [6:0] gw_reg, gh_reg;
    logic [15:0] cs_reg;
    logic signed [15:0] dflt_floor_reg, dflt_ceil_reg;

    logic signed [23:0] cx_reg, cz_reg;
    logic [10:0] rad_reg;
    logic [1:0] div_idx_reg;
    logic [4:0] bit_cnt_reg;
    logic div_neg_reg;
    logic [15:0] rem_reg;
    logic [23:0] quo_reg;
    cell_coord_t q_reg [4];

    cell_coord_t x0_reg, x1_reg, y0_reg, y1_reg;
    logic [XW-1:0] wx_reg;
    logic [YW-1:0] wy_reg;
    logic rd_vld_reg;

    logic acc_blocked_reg, acc_any_reg;
    logic signed [15:0] acc_floor_reg, acc_ceil_reg;

    logic out_valid_reg;
    logic out_blocked_reg, out_any_reg;
    logic signed [15:0] out_floor_reg, out_ceil_reg;

    logic [8:0] used_w, used_h;
    logic [15:0] cs_eff;
    logic accept;
    logic wr_inbound;
    logic [AW-1:0] wr_addr, walk_addr, ram_addr;
    logic wall_we, floor_we, ceil_we;
    logic wall_wd;
    logic signed [15:0] floor_wd, ceil_wd;
    logic wall_rd;
    logic signed [15:0] floor_rd, ceil_rd;
    logic signed [24:0] div_num;
    logic [16:0] trial;
    logic trial_ge;
    logic [24:0] q_mag;
    cell_coord_t q_final;
    cell_coord_t w_s, h_s;

    always_comb
    begin
        used_w = (9'(gw_reg) > 9'(MAX_COLUMNS)) ? 9'(MAX_COLUMNS) : 9'(gw_reg);
        used_h = (9'(gh_reg) > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : 9'(gh_reg);
        cs_eff = (cs_reg == 16'd0) ? 16'd1 : cs_reg;
        w_s = cell_coord_t'(used_w);
        h_s = cell_coord_t'(used_h);
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign accept = in_valid && in_ready;

    assign wr_inbound = (cell_x >= 8'sd0) && (cell_y >= 8'sd0)
        && (10'(unsigned'(cell_x)) < 10'(used_w))
        && (10'(unsigned'(cell_y)) < 10'(used_h));
    assign wr_addr = AW'(32'(unsigned'(cell_y)) * MAX_COLUMNS
        + 32'(unsigned'(cell_x)));
    assign walk_addr = AW'(32'(wy_reg) * MAX_COLUMNS + 32'(wx_reg));

    always_comb
    begin
        wall_we = 1'b0;
        floor_we = 1'b0;
        ceil_we = 1'b0;
        wall_wd = wall_flag;
        floor_wd = height_value;
        ceil_wd = height_value;
        ram_addr = walk_addr;
        if (state_reg == ST_CLEAR)
        begin
            wall_we = 1'b1;
            floor_we = 1'b1;
            ceil_we = 1'b1;
            wall_wd = 1'b0;
            floor_wd = 16'sd0;
            ceil_wd = CEILING_RESET;
            ram_addr = clr_cnt_reg;
        end
        else if (state_reg == ST_IDLE)
        begin
            ram_addr = wr_addr;
            if (accept && wr_inbound)
            begin
                wall_we = (op == OP_WALL);
                floor_we = (op == OP_FLOOR);
                ceil_we = (op == OP_CEILING);
            end
        end
    end

    gbcq_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_wall_ram (
        .clk(clk), .we(wall_we), .addr(ram_addr), .wdata(wall_wd), .rdata(wall_rd)
    );
    gbcq_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_floor_ram (
        .clk(clk), .we(floor_we), .addr(ram_addr), .wdata(floor_wd), .rdata(floor_rd)
    );
    gbcq_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ceil_ram (
        .clk(clk), .we(ceil_we), .addr(ram_addr), .wdata(ceil_wd), .rdata(ceil_rd)
    );

    always_comb
    begin
        unique case (div_idx_reg)
            2'd0: div_num = 25'(cx_reg) - 25'(signed'({1'b0, rad_reg}));
            2'd1: div_num = 25'(cx_reg) + 25'(signed'({1'b0, rad_reg}));
            2'd2: div_num = 25'(cz_reg) - 25'(signed'({1'b0, rad_reg}));
            default: div_num = 25'(cz_reg) + 25'(signed'({1'b0, rad_reg}));
        endcase
        trial = {rem_reg, quo_reg[23]};
        trial_ge = (trial >= 17'(cs_eff));
        q_mag = 25'(quo_reg) + 25'(rem_reg != 16'd0);
        q_final = div_neg_reg ? -cell_coord_t'(q_mag) : cell_coord_t'(quo_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == AW'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE: if (accept && op == OP_QUERY) state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:
                if (bit_cnt_reg == 5'(DIV_STEPS))
                    state_next = (div_idx_reg == 2'd3) ? ST_CLAMP : ST_LOAD;
            ST_CLAMP:
                state_next = (x0_reg <= x1_reg && y0_reg <= y1_reg) ? ST_WALK : ST_FIN;
            ST_WALK:
                if (cell_coord_t'(wx_reg) == x1_reg && cell_coord_t'(wy_reg) == y1_reg)
                    state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_FIN;
            ST_FIN: if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
            gw_reg <= 7'd64;
            gh_reg <= 7'd64;
            cs_reg <= 16'd256;
            dflt_floor_reg <= 16'sd0;
            dflt_ceil_reg <= CEILING_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GRID_WIDTH: gw_reg <= cfg_data[6:0];
                    REG_GRID_HEIGHT: gh_reg <= cfg_data[6:0];
                    REG_CELL_SIZE: cs_reg <= cfg_data;
                    REG_DEFAULT_FLOOR: dflt_floor_reg <= cfg_data;
                    REG_DEFAULT_CEILING: dflt_ceil_reg <= cfg_data;
                    default: ;
                endcase
            end
            rd_vld_reg <= (state_reg == ST_WALK);
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_FIN && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg <= center_x;
            cz_reg <= center_z;
            rad_reg <= radius;
            div_idx_reg <= 2'd0;
        end
        if (state_reg == ST_LOAD)
        begin
            div_neg_reg <= div_num[24];
            quo_reg <= div_num[24] ? 24'(-div_num) : div_num[23:0];
            rem_reg <= 16'd0;
            bit_cnt_reg <= 5'd0;
        end
        if (state_reg == ST_DIV)
        begin
            if (bit_cnt_reg == 5'(DIV_STEPS))
            begin
                q_reg[div_idx_reg] <= q_final;
                div_idx_reg <= div_idx_reg + 2'd1;
            end
            else
            begin
                rem_reg <= trial_ge ? 16'(trial - 17'(cs_eff)) : trial[15:0];
                quo_reg <= {quo_reg[22:0], trial_ge};
                bit_cnt_reg <= bit_cnt_reg + 5'd1;
            end
        end
        if (state_reg == ST_CLAMP)
        begin
            wx_reg <= XW'(x0_reg);
            wy_reg <= YW'(y0_reg);
        end
        else if (state_reg == ST_WALK)
        begin
            if (cell_coord_t'(wx_reg) == x1_reg)
            begin
                wx_reg <= XW'(x0_reg);
                wy_reg <= wy_reg + 1'b1;
            end
            else
            begin
                wx_reg <= wx_reg + 1'b1;
            end
        end
        if (state_reg == ST_DIV && div_idx_reg == 2'd3 && bit_cnt_reg == 5'(DIV_STEPS))
        begin
            x0_reg <= (q_reg[0] < 0) ? '0 : q_reg[0];
            x1_reg <= (q_reg[1] > w_s - 1) ? cell_coord_t'(w_s - 1) : q_reg[1];
            y0_reg <= (q_reg[2] < 0) ? '0 : q_reg[2];
            y1_reg <= (q_final > h_s - 1) ? cell_coord_t'(h_s - 1) : q_final;
            acc_blocked_reg <= (q_reg[0] < 0) || (q_reg[1] >= w_s)
                || (q_reg[2] < 0) || (q_final >= h_s);
            acc_any_reg <= 1'b0;
            acc_floor_reg <= dflt_floor_reg;
            acc_ceil_reg <= dflt_ceil_reg;
        end
        if (rd_vld_reg)
        begin
            if (wall_rd)
            begin
                acc_blocked_reg <= 1'b1;
            end
            else
            begin
                if (!acc_any_reg || floor_rd > acc_floor_reg) acc_floor_reg <= floor_rd;
                if (!acc_any_reg || ceil_rd < acc_ceil_reg) acc_ceil_reg <= ceil_rd;
                acc_any_reg <= 1'b1;
            end
        end
        if (state_reg == ST_FIN && (!out_valid_reg || out_ready))
        begin
            out_blocked_reg <= acc_blocked_reg;
            out_any_reg <= acc_any_reg;
            out_floor_reg <= acc_floor_reg;
            out_ceil_reg <= acc_ceil_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign blocked = out_blocked_reg;
    assign max_floor = out_floor_reg;
    assign min_ceiling = out_ceil_reg;
    assign any_open = out_any_reg;
endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for grid_box_collision_query_unit: directed table, then random
// cell writes and box queries over several grid settings, each checked against an internal model.
// Depends on gbcq_pkg and the design files of the unit.
`timescale 1ns / 1ps

module tb;
    import gbcq_pkg::*;

    localparam int COLS = 64;
    localparam int ROWS = 64;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [7:0]  cx;
        logic signed [7:0]  cy;
        logic               wf;
        logic signed [15:0] hv;
        logic signed [23:0] px;
        logic signed [23:0] pz;
        logic [10:0]        rad;
    } word_t;

    typedef struct packed {
        logic               blk;
        logic signed [15:0] flo;
        logic signed [15:0] ceil;
        logic               open;
    } hit_t;

    typedef struct {
        word_t w;
        bit    typed;
        hit_t  r;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         op;
    logic signed [7:0]  cell_x;
    logic signed [7:0]  cell_y;
    logic               wall_flag;
    logic signed [15:0] height_value;
    logic signed [23:0] center_x;
    logic signed [23:0] center_z;
    logic [10:0]        radius;
    logic               out_valid;
    logic               out_ready;
    logic               blocked;
    logic signed [15:0] max_floor;
    logic signed [15:0] min_ceiling;
    logic               any_open;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;

    grid_box_collision_query_unit uut (.*);

    logic               wall_m [COLS*ROWS];
    logic signed [15:0] floor_m [COLS*ROWS];
    logic signed [15:0] ceil_m [COLS*ROWS];
    logic [6:0]         g_width;
    logic [6:0]         g_height;
    logic [15:0]        g_cell;
    logic signed [15:0] g_def_floor;
    logic signed [15:0] g_def_ceil;

    hit_t pending_hits[$];
    int   errors = 0;
    int   n_queries = 0;
    int   n_writes = 0;
    int   n_results = 0;
    int   tx_idle = 0;
    int   rx_stall = 0;
    bit   hold_req = 0;
    row_t dir[$];

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #400_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic longint div_down(longint n, longint d);
        if (n >= 0)
            return n / d;
        return -((-n + d - 1) / d);
    endfunction

    function automatic longint used_w();
        return (g_width > COLS) ? COLS : g_width;
    endfunction

    function automatic longint used_h();
        return (g_height > ROWS) ? ROWS : g_height;
    endfunction

    function automatic hit_t box_query(word_t w);
        hit_t   r;
        longint cs;
        longint x0;
        longint x1;
        longint y0;
        longint y1;
        longint wd;
        longint ht;
        int     idx;
        cs = (g_cell == 0) ? 1 : g_cell;
        wd = used_w();
        ht = used_h();
        x0 = div_down(longint'(w.px) - w.rad, cs);
        x1 = div_down(longint'(w.px) + w.rad, cs);
        y0 = div_down(longint'(w.pz) - w.rad, cs);
        y1 = div_down(longint'(w.pz) + w.rad, cs);
        r.blk = (x0 < 0 || x1 >= wd || y0 < 0 || y1 >= ht);
        r.open = 1'b0;
        r.flo = g_def_floor;
        r.ceil = g_def_ceil;
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > wd - 1) x1 = wd - 1;
        if (y1 > ht - 1) y1 = ht - 1;
        for (longint y = y0; y <= y1; y++)
        begin
            for (longint x = x0; x <= x1; x++)
            begin
                idx = int'(y * COLS + x);
                if (wall_m[idx])
                    r.blk = 1'b1;
                else
                begin
                    if (!r.open || floor_m[idx] > r.flo) r.flo = floor_m[idx];
                    if (!r.open || ceil_m[idx] < r.ceil) r.ceil = ceil_m[idx];
                    r.open = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic void cell_write(word_t w);
        int idx;
        if (w.cx < 0 || w.cx >= used_w() || w.cy < 0 || w.cy >= used_h())
            return;
        idx = int'(w.cy) * COLS + int'(w.cx);
        case (w.op)
            OP_WALL:  wall_m[idx] = w.wf;
            OP_FLOOR: floor_m[idx] = w.hv;
            default:  ceil_m[idx] = w.hv;
        endcase
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %0h, wanted %0h (result %0d)", what, got, want, n_results);
        errors++;
    endtask

    always @(posedge clk)
    begin
        hit_t e;
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (pending_hits.size() == 0)
                report("unexpected word", 0, 0);
            else
            begin
                e = pending_hits.pop_front();
                if (blocked !== e.blk) report("blocked", blocked, e.blk);
                if (max_floor !== e.flo) report("max_floor", max_floor, e.flo);
                if (min_ceiling !== e.ceil) report("min_ceiling", min_ceiling, e.ceil);
                if (any_open !== e.open) report("any_open", any_open, e.open);
            end
        end
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && hold_left == 0)
            begin
                hold_left = 600;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= rx_stall);
        end
    end

    task automatic put_word(word_t w, bit typed, hit_t r);
        bit acc;
        while ($urandom_range(0, 99) < tx_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= w.op;
        cell_x <= w.cx;
        cell_y <= w.cy;
        wall_flag <= w.wf;
        height_value <= w.hv;
        center_x <= w.px;
        center_z <= w.pz;
        radius <= w.rad;
        do
        begin
            @(negedge clk);
            acc = in_ready;
            @(posedge clk);
        end
        while (!acc);
        if (w.op == OP_QUERY)
        begin
            n_queries++;
            pending_hits.push_back(typed ? r : box_query(w));
        end
        else
        begin
            n_writes++;
            cell_write(w);
        end
    endtask

    task automatic set_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_GRID_WIDTH:    g_width = val[6:0];
            REG_GRID_HEIGHT:   g_height = val[6:0];
            REG_CELL_SIZE:     g_cell = val;
            REG_DEFAULT_FLOOR: g_def_floor = val;
            default:           g_def_ceil = val;
        endcase
    endtask

    task automatic drain_and_configure(int wd, int ht, int cs, int df, int dc);
        in_valid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        set_reg(REG_GRID_WIDTH, 16'(wd));
        set_reg(REG_GRID_HEIGHT, 16'(ht));
        set_reg(REG_CELL_SIZE, 16'(cs));
        set_reg(REG_DEFAULT_FLOOR, 16'(df));
        set_reg(REG_DEFAULT_CEILING, 16'(dc));
        cfg_we <= 1'b0;
    endtask

    function automatic word_t random_word();
        word_t  w;
        longint cs;
        longint span_x;
        longint span_z;
        w = word_t'({$urandom, $urandom, $urandom});
        if ($urandom_range(0, 9) == 0)
            return w;
        cs = (g_cell == 0) ? 1 : g_cell;
        if ($urandom_range(0, 1) == 0)
        begin
            w.op = 2'($urandom_range(0, 2));
            w.cx = 8'(int'($urandom_range(0, used_w() + 3)) - 2);
            w.cy = 8'(int'($urandom_range(0, used_h() + 3)) - 2);
        end
        else
        begin
            w.op = OP_QUERY;
            span_x = (used_w() + 1) * cs;
            span_z = (used_h() + 1) * cs;
            w.px = 24'(longint'($urandom_range(0, 32'(span_x))) - cs / 2);
            w.pz = 24'(longint'($urandom_range(0, 32'(span_z))) - cs / 2);
            if ($urandom_range(0, 4) != 0)
                w.rad = 11'($urandom_range(0, 600));
        end
        return w;
    endfunction

    task automatic random_phase(int count);
        hit_t none;
        none = '0;
        repeat (count) put_word(random_word(), 1'b0, none);
    endtask

    function automatic row_t mk(logic [1:0] o, int x, int y, bit wf, int hv, int px, int pz,
                                int rad, bit typed, hit_t r);
        row_t t;
        t.w = '{o, 8'(x), 8'(y), wf, 16'(hv), 24'(px), 24'(pz), 11'(rad)};
        t.typed = typed;
        t.r = r;
        return t;
    endfunction

    initial
    begin
        hit_t none;
        hit_t empty_blk;
        none = '0;
        empty_blk = '{1'b1, 16'sd0, CEILING_RESET, 1'b0};
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_WALL;
        cell_x = '0;
        cell_y = '0;
        wall_flag = 1'b0;
        height_value = '0;
        center_x = '0;
        center_z = '0;
        radius = '0;
        cfg_we = 1'b0;
        cfg_index = REG_GRID_WIDTH;
        cfg_data = '0;
        g_width = 64;
        g_height = 64;
        g_cell = 256;
        g_def_floor = 0;
        g_def_ceil = CEILING_RESET;
        for (int i = 0; i < COLS * ROWS; i++)
        begin
            wall_m[i] = 1'b0;
            floor_m[i] = '0;
            ceil_m[i] = CEILING_RESET;
        end

        dir.push_back(mk(OP_QUERY, 0, 0, 0, 0, 128, 128, 0, 1,
                         '{1'b0, 16'sd0, CEILING_RESET, 1'b1}));
        dir.push_back(mk(OP_QUERY, 0, 0, 0, 0, -1, 128, 0, 1, empty_blk));
        dir.push_back(mk(OP_WALL, 0, 0, 1, 0, 0, 0, 0, 0, none));
        dir.push_back(mk(OP_QUERY, 0, 0, 0, 0, 128, 128, 0, 1, empty_blk));
        dir.push_back(mk(OP_FLOOR, 0, 0, 0, 32767, 0, 0, 0, 0, none));
        dir.push_back(mk(OP_CEILING, 0, 0, 0, -32768, 0, 0, 0, 0, none));
        dir.push_back(mk(OP_WALL, 0, 0, 0, 0, 0, 0, 0, 0, none));
        dir.push_back(mk(OP_QUERY, 0, 0, 0, 0, 128, 128, 0, 1,
                         '{1'b0, 16'sh7fff, 16'sh8000, 1'b1}));
        dir.push_back(mk(OP_FLOOR, -1, 0, 0, 1000, 0, 0, 0, 0, none));
        dir.push_back(mk(OP_FLOOR, 64, 0, 0, 1000, 0, 0, 0, 0, none));
        dir.push_back(mk(OP_FLOOR, 0, 64, 0, 1000, 0, 0, 0, 0, none));
        dir.push_back(mk(OP_CEILING, 127, -128, 0, 5, 0, 0, 0, 0, none));
        dir.push_back(mk(OP_FLOOR, 63, 63, 0, -32768, 0, 0, 0, 0, none));
        dir.push_back(mk(OP_WALL, 63, 62, 1, 0, 0, 0, 0, 0, none));
        dir.push_back(mk(OP_FLOOR, 63, 62, 0, 9999, 0, 0, 0, 0, none));
        dir.push_back(mk(OP_QUERY, 0, 0, 0, 0, 8388607, 8388607, 2047, 1, empty_blk));
        dir.push_back(mk(OP_QUERY, 0, 0, 0, 0, -8388608, -8388608, 2047, 1, empty_blk));
        dir.push_back(mk(OP_QUERY, 0, 0, 0, 0, 16256, 16256, 0, 0, none));
        dir.push_back(mk(OP_QUERY, 0, 0, 0, 0, 16256, 16000, 300, 0, none));
        dir.push_back(mk(OP_QUERY, 0, 0, 0, 0, 8192, 8192, 2047, 0, none));
        dir.push_back(mk(OP_WALL, 5, 5, 1, 0, 0, 0, 0, 0, none));
        dir.push_back(mk(OP_QUERY, 0, 0, 0, 0, 1408, 1408, 300, 0, none));
        dir.push_back(mk(OP_QUERY, 0, 0, 0, 0, 200, 200, 2047, 0, none));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir[i])
            put_word(dir[i].w, dir[i].typed, dir[i].r);

        random_phase(300);

        drain_and_configure(8, 8, 16, -32768, 32767);
        tx_idle = 65;
        random_phase(300);

        drain_and_configure(127, 127, 65535, 32767, -32768);
        tx_idle = 0;
        rx_stall = 65;
        hold_req = 1;
        random_phase(300);

        drain_and_configure(0, 5, 0, 12, -12);
        tx_idle = 9;
        rx_stall = 9;
        random_phase(100);

        drain_and_configure(1, 1, 1, -1, 1);
        random_phase(100);

        drain_and_configure(64, 3, 512, 100, -100);
        tx_idle = 0;
        rx_stall = 65;
        random_phase(300);

        in_valid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Covered %0d cell writes and %0d box queries over six grid settings,",
                 n_writes, n_queries);
        $display("including empty, clamped and single-cell grids; %0d results checked.",
                 n_results);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

FILE: filelist.f
design/gbcq_pkg.sv
design/gbcq_ram.sv
design/grid_box_collision_query_unit.sv
tb/sv/tb.sv
